// ===== rtl/core/itf_pkg.sv =====
// Package: sizes, character codes, queue entry and state types of the integer formatter.
package itf_pkg;

  localparam int VALUE_WIDTH = 16;
  localparam int MAX_DIGITS  = 32;
  localparam int WIDTH_W     = 6;
  localparam int MODE_W      = 2;
  localparam int CHAR_W      = 7;

  // decimal digits of the largest value: VALUE_WIDTH * log10(2), rounded up
  localparam int DEC_DIGITS  = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int BCD_W       = 4 * DEC_DIGITS;
  localparam int DIG_W       = (BCD_W > VALUE_WIDTH) ? BCD_W : VALUE_WIDTH;
  localparam int NAT_W       = $clog2(DIG_W + 1);
  localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
  localparam int POS_W       = $clog2(MAX_DIGITS);
  localparam int STEP_W      = $clog2(VALUE_WIDTH);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [MODE_W-1:0] MODE_HEX = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BIN = 2'd1;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_A    = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_X    = 7'h78;
  localparam logic [CHAR_W-1:0] CHAR_B    = 7'h62;

  typedef enum logic [1:0] {
    RADIX_HEX,
    RADIX_BIN,
    RADIX_DEC
  } radix_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_HEX0,
    B_HEXX,
    B_BINB,
    B_DIG
  } back_state_e;

  // one classified number waiting for the character engine
  typedef struct packed {
    logic [DIG_W-1:0] digits;
    radix_e           radix;
    logic [CNT_W-1:0] count;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/core/itf_channels.sv =====
// Channel interfaces: number request in, character stream out.
interface itf_in_if import itf_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;
  logic [MODE_W-1:0]      mode;
  logic [WIDTH_W-1:0]     min_width;

  modport source (output valid, value, mode, min_width, input ready);
  modport sink   (input valid, value, mode, min_width, output ready);
endinterface

interface itf_out_if import itf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last;

  modport source (output valid, char_code, last, input ready);
  modport sink   (input valid, char_code, last, output ready);
endinterface

// ===== rtl/core/itf_front.sv =====
// Front end: accepts a request, converts a decimal request's value to BCD, sizes the digit run.
module itf_front import itf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  itf_in_if.sink     req_i,
  input  q_status_t  q_stat_i,
  output logic       push_o,
  output job_t       job_o
);

  front_state_e           state_q, state_d;
  logic [VALUE_WIDTH-1:0] value_q;
  logic [VALUE_WIDTH-1:0] sh_q;
  logic [BCD_W-1:0]       bcd_q;
  logic [BCD_W-1:0]       bcd_adj;
  logic [STEP_W-1:0]      step_q;
  radix_e                 radix_q;
  radix_e                 radix_c;
  logic [WIDTH_W-1:0]     width_q;
  logic                   accept;
  logic [DIG_W-1:0]       digits_c;
  logic [NAT_W-1:0]       nat_bit;
  logic [NAT_W-1:0]       nat_nib;
  logic [NAT_W-1:0]       natural;
  logic [CNT_W-1:0]       nat_cap;
  logic [CNT_W-1:0]       width_cap;

  always_comb begin
    case (req_i.mode)
      MODE_HEX: radix_c = RADIX_HEX;
      MODE_BIN: radix_c = RADIX_BIN;
      default:  radix_c = RADIX_DEC;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (req_i.valid) state_d = (radix_c == RADIX_DEC) ? F_CONV : F_PUSH;
      end
      F_CONV: begin
        if (step_q == '0) state_d = F_PUSH;
      end
      F_PUSH: begin
        if (!q_stat_i.full) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_i.ready = 1'b0;
    push_o      = 1'b0;
    case (state_q)
      F_IDLE:  req_i.ready = 1'b1;
      F_PUSH:  push_o      = !q_stat_i.full;
      default: begin
        req_i.ready = 1'b0;
        push_o      = 1'b0;
      end
    endcase
  end

  assign accept = req_i.valid && req_i.ready;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int d = 0; d < DEC_DIGITS; d++) begin
      bcd_adj[4*d +: 4] = (bcd_q[4*d +: 4] >= 4'd5) ? bcd_q[4*d +: 4] + 4'd3
                                                     : bcd_q[4*d +: 4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      value_q <= req_i.value;
      sh_q    <= req_i.value;
      bcd_q   <= '0;
      step_q  <= STEP_W'(VALUE_WIDTH - 1);
      radix_q <= radix_c;
      width_q <= req_i.min_width;
    end else if (state_q == F_CONV) begin
      bcd_q  <= {bcd_adj[BCD_W-2:0], sh_q[VALUE_WIDTH-1]};
      sh_q   <= {sh_q[VALUE_WIDTH-2:0], 1'b0};
      step_q <= step_q - 1'b1;
    end
  end

  assign digits_c = (radix_q == RADIX_DEC) ? DIG_W'(bcd_q) : DIG_W'(value_q);

  // highest nonzero digit, at least one digit
  always_comb begin
    nat_bit = NAT_W'(1);
    nat_nib = NAT_W'(1);
    for (int i = 0; i < DIG_W; i++) begin
      if (digits_c[i]) begin
        nat_bit = NAT_W'(i + 1);
        nat_nib = NAT_W'((i >> 2) + 1);
      end
    end
  end

  always_comb begin
    natural   = (radix_q == RADIX_BIN) ? nat_bit : nat_nib;
    nat_cap   = (natural > MAX_DIGITS) ? CNT_W'(MAX_DIGITS) : CNT_W'(natural);
    width_cap = (width_q > MAX_DIGITS) ? CNT_W'(MAX_DIGITS) : CNT_W'(width_q);
    job_o.digits = digits_c;
    job_o.radix  = radix_q;
    job_o.count  = (width_cap > nat_cap) ? width_cap : nat_cap;
  end

endmodule

// ===== rtl/core/itf_queue.sv =====
// Short job queue between the front end and the character engine.
module itf_queue import itf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  job_t      job_i,
  input  logic      pop_i,
  output job_t      job_o,
  output q_status_t stat_o
);

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign stat_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign job_o        = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= job_i;
  end

endmodule

// ===== rtl/core/itf_back.sv =====
// Char engine: emits job prefix and digits, one char per cycle unless stalled.
module itf_back import itf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  job_t      job_i,
  input  q_status_t q_stat_i,
  output logic      pop_o,
  itf_out_if.source rsp_o
);

  back_state_e       state_q, state_d;
  job_t              job_q;
  logic [POS_W-1:0]  pos_q;
  logic              valid_q;
  logic [CHAR_W-1:0] char_q;
  logic              last_q;
  logic              adv;
  logic              emit;
  logic [CHAR_W-1:0] char_c;
  logic              last_c;
  logic [DIG_W-1:0]  nib_sh;
  logic [DIG_W-1:0]  bit_sh;
  logic [3:0]        digit;

  // output register frees up when empty or being taken
  assign adv = !valid_q || rsp_o.ready;

  always_comb begin
    nib_sh = job_q.digits >> {pos_q, 2'b00};
    bit_sh = job_q.digits >> pos_q;
    digit  = (job_q.radix == RADIX_BIN) ? {3'b000, bit_sh[0]} : nib_sh[3:0];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (!q_stat_i.empty) begin
          case (job_i.radix)
            RADIX_HEX: state_d = B_HEX0;
            RADIX_BIN: state_d = B_BINB;
            default:   state_d = B_DIG;
          endcase
        end
      end
      B_HEX0: if (adv) state_d = B_HEXX;
      B_HEXX: if (adv) state_d = B_DIG;
      B_BINB: if (adv) state_d = B_DIG;
      B_DIG:  if (adv && pos_q == '0) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop_o  = 1'b0;
    emit   = 1'b0;
    char_c = CHAR_ZERO;
    last_c = 1'b0;
    case (state_q)
      B_IDLE: pop_o = !q_stat_i.empty;
      B_HEX0: begin
        emit   = adv;
        char_c = CHAR_ZERO;
      end
      B_HEXX: begin
        emit   = adv;
        char_c = CHAR_X;
      end
      B_BINB: begin
        emit   = adv;
        char_c = CHAR_B;
      end
      B_DIG: begin
        emit   = adv;
        char_c = (digit < 4'd10) ? CHAR_ZERO + CHAR_W'(digit)
                                 : CHAR_A + CHAR_W'(digit) - CHAR_W'(10);
        last_c = (pos_q == '0);
      end
      default: begin
        pop_o = 1'b0;
        emit  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (adv) valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
      pos_q <= POS_W'(job_i.count - 1'b1);
    end else if (emit && state_q == B_DIG) begin
      pos_q <= pos_q - 1'b1;
    end
    if (emit) begin
      char_q <= char_c;
      last_q <= last_c;
    end
  end

  assign rsp_o.valid     = valid_q;
  assign rsp_o.char_code = char_q;
  assign rsp_o.last      = last_q;

endmodule

// ===== rtl/core/integer_to_ascii_formatter.sv =====
// Top level: number to ASCII character stream in hexadecimal, binary or decimal.
// Front end accepts a request and pushes the job; for decimal it first runs the
// BCD conversion (one BCD shift step per cycle). The character engine loads a
// job in its idle state, then emits its characters, stalling while the output
// is not taken. A 2-entry queue overlaps the two, so the front end can take the
// next request while the engine emits the last one. Reset clears control only.
module integer_to_ascii_formatter import itf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  itf_in_if.sink    req_i,
  itf_out_if.source rsp_o
);

  job_t      push_job, pop_job;
  logic      push, pop;
  q_status_t q_stat;

  itf_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .job_o    (push_job)
  );

  itf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .job_o  (pop_job),
    .stat_o (q_stat)
  );

  itf_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .job_i    (pop_job),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .rsp_o    (rsp_o)
  );

endmodule

// ===== rtl/core/itf_checker.sv =====
// Checker on the formatter's output port, bound to the top level.
module itf_checker import itf_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [CHAR_W-1:0] out_char_i,
  input logic              out_last_i
);

  // hold a stalled character
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_char_i) && $stable(out_last_i))
    else $error("stalled character changed");

  a_charset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_char_i >= CHAR_ZERO && out_char_i <= CHAR_ZERO + 7'd9) ||
                    (out_char_i >= CHAR_A && out_char_i <= CHAR_A + 7'd5) ||
                    out_char_i == CHAR_X || out_char_i == CHAR_B)
    else $error("character outside digit and prefix set");

  // a prefix never ends a number
  a_prefix_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_char_i == CHAR_X || out_char_i == CHAR_B) |-> !out_last_i)
    else $error("prefix marked as last");

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("output valid during reset");

endmodule

bind integer_to_ascii_formatter itf_checker u_itf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .out_char_i  (rsp_o.char_code),
  .out_last_i  (rsp_o.last)
);
